// ===== sv/iso2sj_pkg.sv =====
// iso2sj_pkg: shared types, codes and constants for the ISO-2022-JP to Shift_JIS converter
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package iso2sj_pkg;

  localparam int unsigned MaxResults = 3;
  localparam int unsigned CountW     = 2;

  // byte codes
  localparam logic [7:0] ByteEsc      = 8'h1b;
  localparam logic [7:0] ByteSo       = 8'h0e;
  localparam logic [7:0] ByteSi       = 8'h0f;
  localparam logic [7:0] ByteDollar   = 8'h24;
  localparam logic [7:0] ByteParen    = 8'h28;
  localparam logic [7:0] ByteFinalB   = 8'h42;
  localparam logic [7:0] ByteFinalAt  = 8'h40;
  localparam logic [7:0] ByteFinalI   = 8'h49;
  localparam logic [7:0] JisRowSplit  = 8'h5e;
  localparam logic [7:0] JisLowBase   = 8'h71;
  localparam logic [7:0] JisHighBase  = 8'hb1;
  localparam logic [7:0] TrailOddLow  = 8'h1f;
  localparam logic [7:0] TrailOddHigh = 8'h20;
  localparam logic [7:0] TrailEven    = 8'h7e;
  localparam logic [7:0] TrailSplit   = 8'h60;
  localparam logic [7:0] HighBit      = 8'h80;

  typedef enum logic [1:0] {
    CS_ASCII = 2'd0,
    CS_JIS   = 2'd1,
    CS_KANA  = 2'd2
  } charset_e;

  // pending sequence, one-hot
  typedef enum logic [3:0] {
    SEQ_NONE = 4'b0001,
    SEQ_ESC  = 4'b0010,
    SEQ_SJIS = 4'b0100,
    SEQ_JIS  = 4'b1000
  } seq_e;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_END  = 1'b1
  } out_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              out_kind;
    logic [CountW-1:0] held_count;
    logic              out_last;
  } out_item_t;

  typedef out_item_t [MaxResults-1:0] out_batch_t;

  typedef struct packed {
    charset_e          char_set;
    seq_e              seq_kind;
    logic [CountW-1:0] seq_count;
    logic [7:0]        first_held;
    logic [7:0]        second_held;
  } conv_state_t;

  // Shift_JIS lead byte ranges
  function automatic logic is_sjis_lead(input logic [7:0] b);
    return ((b >= 8'h81) && (b <= 8'h9f)) || ((b >= 8'he0) && (b <= 8'hef));
  endfunction

endpackage

`default_nettype wire

// ===== sv/iso2sj_decode.sv =====
// iso2sj_decode: combinational decode of one byte against the converter state
// depends on iso2sj_pkg; used by iso2022jp_to_shift_jis
`timescale 1ns / 1ps
`default_nettype none

module iso2sj_decode import iso2sj_pkg::*; (
  input  conv_state_t       state_i,
  input  in_item_t          item_i,
  output conv_state_t       state_o,
  output out_batch_t        batch_o,
  output logic [CountW-1:0] batch_n_o
);

  logic [7:0]        b;
  logic [7:0]        a0;
  logic [7:0]        a0_dec;
  logic [7:0]        s0;
  logic [7:0]        add;
  logic [7:0]        byte0;
  logic [7:0]        byte1;
  logic [CountW-1:0] nbytes;
  conv_state_t       nxt;
  out_item_t         marker;

  assign b      = item_i.data_byte;
  assign a0     = state_i.first_held;
  assign a0_dec = a0 - 8'd1;

  // JIS X 0208 pair to Shift_JIS pair
  always_comb begin
    s0 = (a0_dec >> 1) + ((a0 <= JisRowSplit) ? JisLowBase : JisHighBase);
    if (a0[0]) begin
      add = (b < TrailSplit) ? TrailOddLow : TrailOddHigh;
    end else begin
      add = TrailEven;
    end
  end

  // sequence tracking and byte conversion
  always_comb begin
    nxt    = state_i;
    byte0  = '0;
    byte1  = '0;
    nbytes = '0;
    unique case (state_i.seq_kind)
      SEQ_ESC: begin
        if (state_i.seq_count < CountW'(2)) begin
          nxt.second_held = b;
          nxt.seq_count   = CountW'(2);
        end else begin
          if (state_i.second_held == ByteDollar && (b == ByteFinalB || b == ByteFinalAt)) begin
            nxt.char_set = CS_JIS;
          end else if (state_i.second_held == ByteParen && b == ByteFinalI) begin
            nxt.char_set = CS_KANA;
          end else begin
            nxt.char_set = CS_ASCII;
          end
          nxt.seq_kind    = SEQ_NONE;
          nxt.seq_count   = '0;
          nxt.first_held  = '0;
          nxt.second_held = '0;
        end
      end
      SEQ_SJIS: begin
        byte0           = a0;
        byte1           = b;
        nbytes          = CountW'(2);
        nxt.seq_kind    = SEQ_NONE;
        nxt.seq_count   = '0;
        nxt.first_held  = '0;
        nxt.second_held = '0;
      end
      SEQ_JIS: begin
        byte0           = s0;
        byte1           = b + add;
        nbytes          = CountW'(2);
        nxt.seq_kind    = SEQ_NONE;
        nxt.seq_count   = '0;
        nxt.first_held  = '0;
        nxt.second_held = '0;
      end
      default: begin
        if (b == ByteEsc) begin
          nxt.seq_kind  = SEQ_ESC;
          nxt.seq_count = CountW'(1);
        end else if (b == ByteSo) begin
          nxt.char_set = CS_KANA;
        end else if (b == ByteSi) begin
          nxt.char_set = CS_ASCII;
        end else if (b >= HighBit) begin
          if (is_sjis_lead(b)) begin
            nxt.seq_kind   = SEQ_SJIS;
            nxt.seq_count  = CountW'(1);
            nxt.first_held = b;
          end else begin
            byte0  = b;
            nbytes = CountW'(1);
          end
        end else if (state_i.char_set == CS_JIS) begin
          nxt.seq_kind   = SEQ_JIS;
          nxt.seq_count  = CountW'(1);
          nxt.first_held = b;
        end else if (state_i.char_set == CS_KANA) begin
          byte0  = b + HighBit;
          nbytes = CountW'(1);
        end else begin
          byte0  = b;
          nbytes = CountW'(1);
        end
      end
    endcase

    // end marker reports what is still held
    marker            = '0;
    marker.out_kind   = KIND_END;
    marker.held_count = nxt.seq_count;
    marker.out_last   = 1'b1;
    if (item_i.end_of_text) begin
      nxt.seq_kind    = SEQ_NONE;
      nxt.seq_count   = '0;
      nxt.first_held  = '0;
      nxt.second_held = '0;
      nxt.char_set    = CS_ASCII;
    end
  end

  // assemble the result batch
  always_comb begin
    batch_o = '0;
    batch_o[0].out_byte = byte0;
    batch_o[1].out_byte = byte1;
    if (item_i.end_of_text) begin
      batch_o[nbytes] = marker;
    end
    batch_n_o = nbytes + CountW'(item_i.end_of_text);
  end

  assign state_o = nxt;

endmodule

`default_nettype wire

// ===== sv/iso2sj_outq.sv =====
// iso2sj_outq: result register that holds one batch and sends it one item per cycle while the receiver does not stall
// depends on iso2sj_pkg; used by iso2022jp_to_shift_jis
`timescale 1ns / 1ps
`default_nettype none

module iso2sj_outq import iso2sj_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_req_i,
  input  out_batch_t        batch_i,
  input  logic [CountW-1:0] batch_n_i,
  output logic              load_ok_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o
);

  out_batch_t        slot_q, slot_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic              take;
  logic              load;

  assign out_valid_o = (rem_q != '0);
  assign out_item_o  = slot_q[0];
  assign take        = out_valid_o && !out_stall_i;
  // a new batch fits once the current one is gone or its last item leaves
  assign load_ok_o   = (rem_q == '0) || (take && rem_q == CountW'(1));
  assign load        = load_req_i && load_ok_o;

  // next batch or shift down
  always_comb begin
    slot_d = slot_q;
    rem_d  = rem_q;
    if (load) begin
      slot_d = batch_i;
      rem_d  = batch_n_i;
    end else if (take) begin
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
      rem_d     = rem_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

`ifndef SYNTHESIS
  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && rem_q > CountW'(1)) |=> out_valid_o)
    else $error("batch lost items");
  a_last_is_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.out_last) |-> (out_item_o.out_kind == KIND_END))
    else $error("last flag on a data byte");
  a_empty_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && batch_n_i == '0) |=> !out_valid_o)
    else $error("empty batch shows a result");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_req_i |-> (batch_n_i <= CountW'(MaxResults)))
    else $error("batch larger than the buffer");
`endif

endmodule

`default_nettype wire

// ===== sv/iso2022jp_to_shift_jis.sv =====
// iso2022jp_to_shift_jis: top level with input register, converter state and result queue
// depends on iso2sj_pkg, iso2sj_decode and iso2sj_outq
//
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one ISO-2022-JP byte per item
//   with an end_of_text flag. Output channel: out_valid_o / out_stall_i carry
//   one Shift_JIS byte or the end marker per item.
//   An accepted byte sits in the input register, is decoded and written as a
//   batch of zero to three results into the result register once the result
//   queue has room; the first item of that register drives the output.
//   Throughput is one input item per cycle while each byte yields at most one
//   result and the receiver does not stall; a byte that yields two or three
//   results keeps the result queue busy while they leave one by one through
//   its single output port, and the next byte waits in the input register
//   until the last of them leaves. Escape, shift codes and lead bytes only change
//   state unless they end the text. When the receiver stalls, the result queue holds
//   its item, then the input register fills and in_stall_o rises; no item is dropped.
//   Reset clears the valid flags and returns the converter to ASCII with no
//   pending sequence. After an end_of_text item the converter is back in ASCII.
`timescale 1ns / 1ps
`default_nettype none

module iso2022jp_to_shift_jis import iso2sj_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic              in_valid_q, in_valid_d;
  in_item_t          in_item_q;
  conv_state_t       state_q, state_d;
  conv_state_t       state_next;
  out_batch_t        batch;
  logic [CountW-1:0] batch_n;
  logic              load_ok;
  logic              consume;
  logic              in_accept;

  iso2sj_decode u_decode (
    .state_i   (state_q),
    .item_i    (in_item_q),
    .state_o   (state_next),
    .batch_o   (batch),
    .batch_n_o (batch_n)
  );

  iso2sj_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_req_i  (in_valid_q),
    .batch_i     (batch),
    .batch_n_i   (batch_n),
    .load_ok_o   (load_ok),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // handshake on the input register
  assign consume    = in_valid_q && load_ok;
  assign in_stall_o = in_valid_q && !load_ok;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
    state_d = consume ? state_next : state_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q          <= 1'b0;
      state_q.char_set    <= CS_ASCII;
      state_q.seq_kind    <= SEQ_NONE;
      state_q.seq_count   <= '0;
      state_q.first_held  <= '0;
      state_q.second_held <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      state_q    <= state_d;
    end
  end

  // input payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_item_i;
    end
  end

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("stall with empty input register");
  a_eot_resets_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && in_item_q.end_of_text) |=>
      (state_q.char_set == CS_ASCII && state_q.seq_kind == SEQ_NONE))
    else $error("state not cleared after end of text");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_iso2022jp_to_shift_jis.sv =====
// tb_iso2022jp_to_shift_jis: self-checking bench for the ISO-2022-JP to Shift_JIS converter
// depends on iso2sj_pkg and iso2022jp_to_shift_jis; directed table, then random text segments
// every accepted result is checked against a typed table row or an in-bench conversion
`timescale 1ns / 1ps

module tb_iso2022jp_to_shift_jis;
  import iso2sj_pkg::*;

  localparam int CycleLimit  = 300000;
  localparam int RandomItems = 340;
  localparam int HoldCycles  = 80;
  localparam int DrainCycles = 20;
  localparam int MaxReports  = 10;

  // Shift_JIS lead byte ranges
  localparam logic [7:0] SjisLeadLoA = 8'h81;
  localparam logic [7:0] SjisLeadHiA = 8'h9f;
  localparam logic [7:0] SjisLeadLoB = 8'he0;
  localparam logic [7:0] SjisLeadHiB = 8'hef;

  typedef struct {
    in_item_t   item;
    int         n_typed;  // -1: expectation comes from the converter model
    out_batch_t typed;
  } stim_rec_t;

  logic      clk_i;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  // converter model state
  charset_e          cur_set;
  seq_e              pend;
  logic [CountW-1:0] pend_cnt;
  logic [7:0]        lead_byte;
  logic [7:0]        esc_second;

  stim_rec_t stim_q [$];
  out_item_t sjis_q [$];
  int        acc_cnt   = 0;
  int        fail_cnt  = 0;
  int        cycles    = 0;
  int        n_dir;
  bit        quiet     = 1'b0;
  bit        hold_go   = 1'b0;

  iso2022jp_to_shift_jis i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic out_item_t mk_byte(input logic [7:0] b);
    out_item_t r;
    r = '0;
    r.out_byte = b;
    r.out_kind = KIND_BYTE;
    return r;
  endfunction

  function automatic out_item_t mk_end(input logic [CountW-1:0] held);
    out_item_t r;
    r = '0;
    r.out_kind   = KIND_END;
    r.held_count = held;
    r.out_last   = 1'b1;
    return r;
  endfunction

  function automatic logic [7:0] rnd8(input int lo, input int hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  function automatic void clear_pending();
    pend       = SEQ_NONE;
    pend_cnt   = '0;
    lead_byte  = '0;
    esc_second = '0;
  endfunction

  // one input byte through the converter model, returns the number of results
  function automatic int convert_byte(input in_item_t it, output out_batch_t res);
    logic [7:0] b;
    logic [7:0] t;
    logic [7:0] s0;
    logic [7:0] add;
    int         n;
    b   = it.data_byte;
    n   = 0;
    res = '0;
    case (pend)
      SEQ_ESC: begin
        if (pend_cnt < 2'd2) begin
          esc_second = b;
          pend_cnt   = 2'd2;
        end else begin
          if (esc_second == ByteDollar && (b == ByteFinalB || b == ByteFinalAt)) begin
            cur_set = CS_JIS;
          end else if (esc_second == ByteParen && b == ByteFinalI) begin
            cur_set = CS_KANA;
          end else begin
            cur_set = CS_ASCII;
          end
          clear_pending();
        end
      end
      SEQ_SJIS: begin
        res[0] = mk_byte(lead_byte);
        res[1] = mk_byte(b);
        n = 2;
        clear_pending();
      end
      SEQ_JIS: begin
        // row byte: (lead - 1) / 2 plus a base, all modulo 256
        t  = lead_byte - 8'd1;
        s0 = (t >> 1) + ((lead_byte <= JisRowSplit) ? JisLowBase : JisHighBase);
        if (lead_byte[0]) begin
          add = (b < TrailSplit) ? TrailOddLow : TrailOddHigh;
        end else begin
          add = TrailEven;
        end
        res[0] = mk_byte(s0);
        res[1] = mk_byte(b + add);
        n = 2;
        clear_pending();
      end
      default: begin
        if (b == ByteEsc) begin
          pend     = SEQ_ESC;
          pend_cnt = 2'd1;
        end else if (b == ByteSo) begin
          cur_set = CS_KANA;
        end else if (b == ByteSi) begin
          cur_set = CS_ASCII;
        end else if (b >= HighBit) begin
          if (b inside {[SjisLeadLoA:SjisLeadHiA], [SjisLeadLoB:SjisLeadHiB]}) begin
            pend      = SEQ_SJIS;
            pend_cnt  = 2'd1;
            lead_byte = b;
          end else begin
            res[0] = mk_byte(b);
            n = 1;
          end
        end else if (cur_set == CS_JIS) begin
          pend      = SEQ_JIS;
          pend_cnt  = 2'd1;
          lead_byte = b;
        end else if (cur_set == CS_KANA) begin
          res[0] = mk_byte(b + HighBit);
          n = 1;
        end else begin
          res[0] = mk_byte(b);
          n = 1;
        end
      end
    endcase
    // end of text drops the pending sequence, reports its length and returns to ASCII
    if (it.end_of_text) begin
      res[n] = mk_end(pend_cnt);
      n++;
      clear_pending();
      cur_set = CS_ASCII;
    end
    return n;
  endfunction

  task automatic row_typed(input logic [7:0] b, input logic eot, input int n,
                           input out_item_t r0, input out_item_t r1);
    stim_rec_t rec;
    rec.item.data_byte   = b;
    rec.item.end_of_text = eot;
    rec.n_typed          = n;
    rec.typed            = '0;
    rec.typed[0]         = r0;
    rec.typed[1]         = r1;
    stim_q.push_back(rec);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic eot);
    row_typed(b, eot, -1, '0, '0);
  endtask

  function automatic logic [7:0] jis_cell();
    return ($urandom_range(7) == 0) ? rnd8(0, 8'h7f) : rnd8(8'h21, 8'h7e);
  endfunction

  // directed table
  task automatic build_table();
    row_typed(8'h00, 1'b1, 2, mk_byte(8'h00), mk_end(2'd0));  // lowest byte right after reset
    row_typed(8'hff, 1'b1, 2, mk_byte(8'hff), mk_end(2'd0));  // highest byte is no lead
    push_byte(ByteEsc, 1'b0);                                 // ESC $ B selects JIS X 0208
    push_byte(ByteDollar, 1'b0);
    push_byte(ByteFinalB, 1'b0);
    push_byte(8'h00, 1'b0);                                   // lead 0x00 wraps
    push_byte(8'h7f, 1'b0);
    push_byte(8'h7f, 1'b0);                                   // odd lead, upper rows, high trail
    push_byte(8'h60, 1'b0);
    push_byte(8'h21, 1'b0);                                   // odd lead, lower rows, low trail
    push_byte(8'h5f, 1'b0);
    push_byte(ByteEsc, 1'b0);                                 // ESC ( I selects kana
    push_byte(ByteParen, 1'b0);
    push_byte(ByteFinalI, 1'b0);
    push_byte(8'h7f, 1'b0);
    push_byte(ByteSi, 1'b0);                                  // shift in, then shift out
    push_byte(ByteSo, 1'b0);
    push_byte(8'h81, 1'b0);                                   // lead carries SO as its trail
    push_byte(ByteSo, 1'b0);
    push_byte(ByteEsc, 1'b0);                                 // ESC ESC SO: unknown pair, ASCII
    push_byte(ByteEsc, 1'b0);
    push_byte(ByteSo, 1'b0);
    push_byte(ByteEsc, 1'b0);                                 // ESC $ @, then a lone lead at end
    push_byte(ByteDollar, 1'b0);
    push_byte(ByteFinalAt, 1'b0);
    row_typed(8'h21, 1'b1, 1, mk_end(2'd1), '0);
    push_byte(ByteEsc, 1'b0);                                 // escape cut short at end
    row_typed(ByteDollar, 1'b1, 1, mk_end(2'd2), '0);
  endtask

  // random text made of well-formed segments, with noise and broken sequences
  task automatic add_random(input int target);
    int start;
    int len;
    start = stim_q.size();
    while (stim_q.size() - start < target) begin
      case ($urandom_range(9))
        0, 1: begin
          if ($urandom_range(1) == 1) push_byte(ByteSi, 1'b0);
          len = $urandom_range(1, 6);
          repeat (len) push_byte(rnd8(8'h20, 8'h7e), 1'b0);
        end
        2, 3: begin
          push_byte(ByteEsc, 1'b0);
          push_byte(ByteDollar, 1'b0);
          push_byte(($urandom_range(1) == 1) ? ByteFinalB : ByteFinalAt, 1'b0);
          len = $urandom_range(1, 4);
          repeat (len) begin
            push_byte(jis_cell(), 1'b0);
            push_byte(jis_cell(), 1'b0);
          end
          push_byte(ByteEsc, 1'b0);
          push_byte(ByteParen, 1'b0);
          push_byte(ByteFinalB, 1'b0);
        end
        4: begin
          if ($urandom_range(1) == 1) begin
            push_byte(ByteEsc, 1'b0);
            push_byte(ByteParen, 1'b0);
            push_byte(ByteFinalI, 1'b0);
          end else begin
            push_byte(ByteSo, 1'b0);
          end
          len = $urandom_range(1, 5);
          repeat (len) begin
            push_byte(($urandom_range(3) == 0) ? rnd8(0, 8'h7f) : rnd8(8'h21, 8'h5f), 1'b0);
          end
          push_byte(ByteSi, 1'b0);
        end
        5: begin
          len = $urandom_range(1, 3);
          repeat (len) begin
            push_byte(($urandom_range(1) == 1) ? rnd8(SjisLeadLoA, SjisLeadHiA)
                                               : rnd8(SjisLeadLoB, SjisLeadHiB), 1'b0);
            push_byte(rnd8(0, 255), 1'b0);
          end
        end
        6: begin
          len = $urandom_range(1, 4);
          repeat (len) push_byte(rnd8(8'h80, 8'hff), 1'b0);
        end
        7: begin
          len = $urandom_range(1, 4);
          repeat (len) push_byte(rnd8(0, 255), 1'b0);
        end
        8: begin
          // sequence broken by the end of text
          case ($urandom_range(2))
            0: push_byte(ByteEsc, 1'b1);
            1: begin
              push_byte(ByteEsc, 1'b0);
              push_byte(rnd8(0, 255), 1'b1);
            end
            default: begin
              push_byte(ByteEsc, 1'b0);
              push_byte(ByteDollar, 1'b0);
              push_byte(ByteFinalB, 1'b0);
              push_byte(rnd8(0, 8'h7f), 1'b1);
            end
          endcase
        end
        default: push_byte(rnd8(0, 255), 1'b1);
      endcase
      if ($urandom_range(9) == 0) stim_q[stim_q.size() - 1].item.end_of_text = 1'b1;
    end
  endtask

  // sender
  initial begin : sender
    int hold_at;
    int pause_at;
    int quiet_lo;
    int quiet_hi;
    cur_set = CS_ASCII;
    clear_pending();
    build_table();
    n_dir = stim_q.size();
    add_random(RandomItems);
    hold_at  = n_dir + 40;
    quiet_lo = n_dir + 120;
    quiet_hi = n_dir + 200;
    pause_at = n_dir + 250;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int k = 0; k < stim_q.size(); k++) begin
      quiet = (k >= quiet_lo) && (k < quiet_hi);
      if (k == hold_at) hold_go = 1'b1;
      // wait for every pending result before going on
      if (k == n_dir || k == pause_at) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
        while (sjis_q.size() != 0) @(posedge clk_i);
      end
      if (!quiet) begin
        while ($urandom_range(99) < 30) begin
          in_valid <= 1'b0;
          @(posedge clk_i);
        end
      end
      in_valid <= 1'b1;
      in_item  <= stim_q[k].item;
      do @(posedge clk_i); while (in_stall_o);
    end
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sjis_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sjis_q.size() != 0) fail_cnt++;
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // receiver stalls, with one long hold-off
  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 30);
      end
    end
  end

  // accepted input item: queue its expected results
  always @(posedge clk_i) begin : in_mon
    stim_rec_t  rec;
    out_batch_t res;
    int         n;
    if (rst_ni && in_valid && !in_stall_o) begin
      rec = stim_q[acc_cnt];
      acc_cnt++;
      n = convert_byte(rec.item, res);
      if (rec.n_typed >= 0) begin
        n   = rec.n_typed;
        res = rec.typed;
      end
      for (int i = 0; i < n; i++) sjis_q.push_back(res[i]);
    end
  end

  // accepted result item: compare with the oldest expectation
  always @(posedge clk_i) begin : out_mon
    out_item_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall) begin
      if (sjis_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MaxReports) begin
          $display("unexpected result: byte %h kind %0d held %0d last %0d",
                   out_item_o.out_byte, out_item_o.out_kind,
                   out_item_o.held_count, out_item_o.out_last);
        end
      end else begin
        want = sjis_q.pop_front();
        if (want.out_byte !== out_item_o.out_byte || want.out_kind !== out_item_o.out_kind ||
            want.held_count !== out_item_o.held_count ||
            want.out_last !== out_item_o.out_last) begin
          fail_cnt++;
          if (fail_cnt <= MaxReports) begin
            $display("mismatch: want %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                     want.out_byte, want.out_kind, want.held_count, want.out_last,
                     out_item_o.out_byte, out_item_o.out_kind,
                     out_item_o.held_count, out_item_o.out_last);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
